// ----- hw/rtl/sos_pkg.sv -----
// shared types and constants of the stochastic oscillator smoother
`default_nettype none

package sos_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 2);
  localparam int CFG_W       = 7;
  localparam int PRICE_W     = 32;
  localparam int Q_W         = 16;
  localparam int Q_FRAC_BITS = 15;
  localparam int QUO_W       = 17;
  localparam int FRAC_W      = 18;
  localparam int SUM_W       = 20;

  localparam logic [CFG_W-1:0]         WIN_RESET = CFG_W'(5);
  localparam logic signed [FRAC_W-1:0] FRAC_HALF = FRAC_W'(16384);
  localparam logic signed [FRAC_W-1:0] FRAC_MAX  = FRAC_W'(65536);
  localparam logic signed [SUM_W-1:0]  SUM_HALF  = SUM_W'(16384);
  localparam logic signed [SUM_W-1:0]  SUM_LIMIT = SUM_W'(32764);
  localparam logic signed [Q_W-1:0]    Q_LIMIT   = Q_W'(32764);

  typedef struct packed {
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
  } bar_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_WALK,
    S_DRAIN,
    S_PREP,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sos_window_mem.sv -----
// ring memory of bar highs and lows, one write and one registered read port
`default_nettype none

module sos_window_mem (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [sos_pkg::SLOT_W-1:0] wr_addr,
  input  wire sos_pkg::bar_t              wr_data,
  input  wire logic                       rd_en,
  input  wire logic [sos_pkg::SLOT_W-1:0] rd_addr,
  output sos_pkg::bar_t                   rd_data
);
  import sos_pkg::*;

  bar_t mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sos_divider.sv -----
// restoring divider, one quotient bit per cycle, for the stochastic fraction
`default_nettype none

module sos_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [sos_pkg::PRICE_W-1:0] dividend_mag,
  input  wire logic [sos_pkg::PRICE_W-1:0] divisor,
  output logic                             done,
  output logic [sos_pkg::QUO_W-1:0]        quotient
);
  import sos_pkg::*;

  localparam int PRE_SHIFT = QUO_W - Q_FRAC_BITS;
  localparam int ITER_W = $clog2(QUO_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(QUO_W - 1);

  logic [PRICE_W-1:0] rem;
  logic [QUO_W-1:0]   bits;
  logic [ITER_W-1:0]  count;
  logic               busy;
  logic [PRICE_W:0]   trial;
  logic [PRICE_W:0]   diff;
  logic               fits;

  assign trial = {rem, bits[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + ITER_W'(1);
        if (count == ITER_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend_mag >> PRE_SHIFT;
      bits     <= {dividend_mag[PRE_SHIFT-1:0], {Q_FRAC_BITS{1'b0}}};
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[PRICE_W-1:0] : trial[PRICE_W-1:0];
      bits     <= {bits[QUO_W-2:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stochastic_oscillator_smoother.sv -----
// top level: sequencer, window walk and smoothing of the stochastic oscillator
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | close_price, high_price, low_price, series_start
//  out      | out_valid / out_ready| smoothed_value, value_valid
//  cfg      | cfg_write            | cfg_data -> window_length
//
//  a warm-up bar goes from accept through the store step straight to the emit step;
//  a full bar also walks the window (n = window length, 1..64) and divides, but
//  skips the divide when the range is flat or inverted or the fraction saturates
//  a full bar walks n entries through the single-read window memory and then uses
//  the 17-step shared divider; in_ready is high only in the idle state
//  one finished result waits in the output register while the next bar is taken
//  rst is synchronous; the window memory is not cleared, series_start restarts
`default_nettype none

module stochastic_oscillator_smoother (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [sos_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sos_pkg::PRICE_W-1:0]   close_price,
  input  wire logic [sos_pkg::PRICE_W-1:0]   high_price,
  input  wire logic [sos_pkg::PRICE_W-1:0]   low_price,
  input  wire logic                          series_start,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [sos_pkg::Q_W-1:0]     smoothed_value,
  output logic                               value_valid
);
  import sos_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]         window_length;
  logic [SLOT_W-1:0]        write_slot;
  logic [CNT_W-1:0]         bars_seen;
  logic signed [Q_W-1:0]    previous_value;
  logic [PRICE_W-1:0]       close_r;
  bar_t                     bar_r;
  logic [CNT_W-1:0]         k;
  logic                     rd_valid;
  logic [PRICE_W-1:0]       lo;
  logic [PRICE_W-1:0]       hi;
  logic [PRICE_W-1:0]       range_r;
  logic [PRICE_W-1:0]       mag;
  logic                     neg;
  logic                     bad_range;
  logic                     warm;
  logic signed [FRAC_W-1:0] frac;

  logic [CNT_W-1:0]         win_n;
  logic                     in_fire;
  logic                     out_free;
  logic                     walk_last;
  logic                     saturate;
  logic                     mem_wr_en;
  logic                     mem_rd_en;
  logic                     div_start;
  logic                     div_done;
  logic [QUO_W-1:0]         div_q;
  logic [QUO_W-1:0]         q_clamp;
  logic [SLOT_W-1:0]        rd_addr;
  bar_t                     rd_data;
  logic signed [SUM_W-1:0]  sum;
  logic signed [Q_W-1:0]    value;

  always_comb begin
    if (window_length == '0) begin
      win_n = CNT_W'(1);
    end else if (CNT_W'(window_length) > CNT_W'(MAX_WINDOW)) begin
      win_n = CNT_W'(MAX_WINDOW);
    end else begin
      win_n = CNT_W'(window_length);
    end
  end

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign walk_last = k == (win_n - CNT_W'(1));
  assign saturate  = (mag >> 1) >= range_r;
  assign rd_addr   = write_slot - k[SLOT_W-1:0];
  assign q_clamp   = (QUO_W'(div_q) > QUO_W'(FRAC_MAX)) ? QUO_W'(FRAC_MAX) : div_q;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_STORE;
      S_STORE: state_next = (bars_seen <= win_n) ? S_EMIT : S_WALK;
      S_WALK:  if (walk_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_PREP;
      S_PREP:  state_next = S_CHECK;
      S_CHECK: state_next = (bad_range || saturate) ? S_EMIT : S_DIV;
      S_DIV:   if (div_done) state_next = S_EMIT;
      S_EMIT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = !rst;
      S_STORE: mem_wr_en = 1'b1;
      S_WALK:  mem_rd_en = 1'b1;
      S_CHECK: div_start = !(bad_range || saturate);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WIN_RESET;
    end else if (cfg_write) begin
      window_length <= cfg_data;
    end
  end

  // series state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      bars_seen      <= '0;
      previous_value <= '0;
    end else begin
      if (in_fire && series_start) begin
        write_slot     <= '0;
        bars_seen      <= '0;
        previous_value <= '0;
      end
      if (state == S_STORE) begin
        bars_seen <= (bars_seen < win_n + CNT_W'(1)) ? bars_seen + CNT_W'(1)
                                                     : win_n + CNT_W'(1);
        if (bars_seen <= win_n) begin
          write_slot <= write_slot + SLOT_W'(1);
        end
      end
      if (state == S_DRAIN) begin
        write_slot <= write_slot + SLOT_W'(1);
      end
      if (state == S_EMIT && out_free) begin
        previous_value <= warm ? '0 : value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= mem_rd_en;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      close_r    <= close_price;
      bar_r.high <= high_price;
      bar_r.low  <= low_price;
    end
    if (state == S_STORE) begin
      warm <= bars_seen <= win_n;
      k    <= '0;
      lo   <= '1;
      hi   <= '0;
    end
    if (state == S_WALK) begin
      k <= k + CNT_W'(1);
    end
    if (rd_valid) begin
      if (rd_data.low < lo) lo <= rd_data.low;
      if (rd_data.high > hi) hi <= rd_data.high;
    end
    if (state == S_PREP) begin
      range_r   <= hi - lo;
      bad_range <= hi <= lo;
      neg       <= close_r < lo;
      mag       <= (close_r < lo) ? lo - close_r : close_r - lo;
    end
    if (state == S_CHECK) begin
      if (bad_range) begin
        frac <= FRAC_HALF;
      end else if (saturate) begin
        frac <= neg ? -FRAC_MAX : FRAC_MAX;
      end
    end
    if (state == S_DIV && div_done) begin
      frac <= neg ? -FRAC_W'($signed({1'b0, q_clamp})) : FRAC_W'($signed({1'b0, q_clamp}));
    end
  end

  // smoothing and clamp
  always_comb begin
    sum = SUM_W'(frac) - SUM_HALF + SUM_W'(previous_value >>> 1);
    if (sum > SUM_LIMIT) begin
      value = Q_LIMIT;
    end else if (sum < -SUM_LIMIT) begin
      value = -Q_LIMIT;
    end else begin
      value = sum[Q_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      smoothed_value <= warm ? '0 : value;
      value_valid    <= !warm;
    end
  end

  sos_window_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (write_slot),
    .wr_data (bar_r),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sos_divider u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .dividend_mag (mag),
    .divisor      (range_r),
    .done         (div_done),
    .quotient     (div_q)
  );

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !value_valid |-> smoothed_value == '0)
    else $error("warm-up beat carries a nonzero value");

  a_value_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (smoothed_value <= Q_LIMIT) && (smoothed_value >= -Q_LIMIT))
    else $error("smoothed value outside clamp");

  a_bars_bound: assert property (@(posedge clk) disable iff (rst)
    bars_seen <= CNT_W'(MAX_WINDOW + 1))
    else $error("bar counter past its saturation point");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> k < win_n)
    else $error("window walk past window length");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV)
    else $error("divider started outside divide step");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench of the stochastic oscillator smoother: directed and random bars checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sos_pkg::*;

  localparam int Q_ONE           = 32768;
  localparam int Q_HALF          = 16384;
  localparam int FRAC_LIMIT      = 2 * Q_ONE;
  localparam int VALUE_LIMIT     = 32764;
  localparam int ITEMS_PER_PHASE = 134;
  localparam int DRAIN_CYCLES    = 100;
  localparam int MAX_CYCLES      = 1000000;

  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  typedef enum int {TREND_DOWN, TREND_FLAT, TREND_UP} trend_t;
  typedef enum int {CLOSE_ANY, CLOSE_NEAR_HIGH, CLOSE_NEAR_LOW} close_bias_t;

  typedef struct {
    logic signed [Q_W-1:0] value;
    logic                  valid;
  } smoothed_bar_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [PRICE_W-1:0]        close_price;
  logic [PRICE_W-1:0]        high_price;
  logic [PRICE_W-1:0]        low_price;
  logic                      series_start;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [Q_W-1:0]     smoothed_value;
  logic                      value_valid;

  smoothed_bar_t             pending_results[$];
  int                        mismatch_count = 0;
  int                        cycle_count = 0;

  logic [CFG_W-1:0]          window_reg = WIN_RESET;
  logic [PRICE_W-1:0]        high_hist [MAX_WINDOW];
  logic [PRICE_W-1:0]        low_hist [MAX_WINDOW];
  int                        next_slot = 0;
  int                        bars_in_series = 0;
  int                        last_value = 0;

  logic [PRICE_W-1:0]        price_level;
  logic [PRICE_W-1:0]        price_spread;
  trend_t                    trend;
  close_bias_t               close_bias;
  int                        burst_left = 0;
  int                        stall_tick = 0;
  int                        stall_mode = 0;

  stochastic_oscillator_smoother DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .close_price    (close_price),
    .high_price     (high_price),
    .low_price      (low_price),
    .series_start   (series_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smoothed_value (smoothed_value),
    .value_valid    (value_valid)
  );

  always #5 clk = ~clk;

  function automatic int active_window();
    if (window_reg == '0) return 1;
    if (int'(window_reg) > MAX_WINDOW) return MAX_WINDOW;
    return int'(window_reg);
  endfunction

  function automatic int stochastic_fraction(logic [PRICE_W-1:0] c, lo, hi);
    logic [63:0] span;
    logic [63:0] mag;
    bit          below;
    if (hi <= lo) return Q_HALF;
    span  = 64'(hi) - 64'(lo);
    below = (c < lo);
    mag   = below ? 64'(lo) - 64'(c) : 64'(c) - 64'(lo);
    if (mag / 2 >= span) return below ? -FRAC_LIMIT : FRAC_LIMIT;
    mag = (mag * 64'(Q_ONE)) / span;
    if (mag > 64'(FRAC_LIMIT)) mag = 64'(FRAC_LIMIT);
    return below ? -int'(mag) : int'(mag);
  endfunction

  task automatic predict_smoothing(logic [PRICE_W-1:0] c, h, l, logic start);
    int                 n;
    int                 base;
    int                 seen;
    int                 j;
    int                 sum;
    logic [PRICE_W-1:0] lo;
    logic [PRICE_W-1:0] hi;
    smoothed_bar_t      r;
    n = active_window();
    if (start) begin
      foreach (high_hist[i]) begin
        high_hist[i] = '0;
        low_hist[i]  = '0;
      end
      next_slot      = 0;
      bars_in_series = 0;
      last_value     = 0;
    end
    base            = next_slot;
    high_hist[base] = h;
    low_hist[base]  = l;
    seen            = bars_in_series;
    bars_in_series  = (bars_in_series < n + 1) ? bars_in_series + 1 : n + 1;
    next_slot       = (base + 1) % MAX_WINDOW;
    if (seen <= n) begin
      last_value = 0;
      r.value    = '0;
      r.valid    = 1'b0;
    end else begin
      lo = low_hist[base];
      hi = high_hist[base];
      for (int k = 1; k < n; k++) begin
        j = (base + MAX_WINDOW - k) % MAX_WINDOW;
        if (low_hist[j] < lo) lo = low_hist[j];
        if (high_hist[j] > hi) hi = high_hist[j];
      end
      sum = stochastic_fraction(c, lo, hi) - Q_HALF + (last_value >>> 1);
      if (sum > VALUE_LIMIT) sum = VALUE_LIMIT;
      if (sum < -VALUE_LIMIT) sum = -VALUE_LIMIT;
      last_value = sum;
      r.value    = Q_W'(sum);
      r.valid    = 1'b1;
    end
    pending_results.push_back(r);
  endtask

  task automatic send_bar(logic [PRICE_W-1:0] c, h, l, logic start);
    in_valid     <= 1'b1;
    close_price  <= c;
    high_price   <= h;
    low_price    <= l;
    series_start <= start;
    do @(posedge clk); while (!in_ready);
    predict_smoothing(c, h, l, start);
  endtask

  // bursts of back-to-back beats separated by random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    window_reg = v;
  endtask

  task automatic new_market();
    price_level  = $urandom();
    price_spread = 32'd1 << $urandom_range(0, 28);
    trend        = trend_t'($urandom_range(0, 2));
    close_bias   = close_bias_t'($urandom_range(0, 2));
  endtask

  task automatic make_bar(output logic [PRICE_W-1:0] c, h, l);
    logic [63:0]        lvl;
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic [63:0]        step;
    logic [PRICE_W-1:0] width;
    int                 pick;
    if ($urandom_range(0, 29) == 0) trend = trend_t'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    lvl  = 64'(price_level);
    step = 64'($urandom_range(0, price_spread));
    if (trend == TREND_UP || (trend == TREND_FLAT && $urandom_range(0, 1) == 1)) begin
      lvl = lvl + step;
      if (lvl > 64'(PRICE_MAX)) lvl = 64'(PRICE_MAX);
    end else begin
      lvl = (step > lvl) ? 64'd0 : lvl - step;
    end
    price_level = PRICE_W'(lvl);
    step  = 64'($urandom_range(0, price_spread));
    lo    = (step > lvl) ? 64'd0 : lvl - step;
    step  = 64'($urandom_range(0, price_spread));
    hi    = lvl + step;
    if (hi > 64'(PRICE_MAX)) hi = 64'(PRICE_MAX);
    width = PRICE_W'(hi - lo);
    h = PRICE_W'(hi);
    l = PRICE_W'(lo);
    if (pick < 80) begin
      case (close_bias)
        CLOSE_NEAR_HIGH: c = h - $urandom_range(0, width >> 3);
        CLOSE_NEAR_LOW:  c = l + $urandom_range(0, width >> 3);
        default:         c = l + $urandom_range(0, width);
      endcase
    end else if (pick < 90) begin
      c = $urandom();
    end else if (pick < 95) begin
      h = PRICE_W'(lo);
      l = PRICE_W'(hi);
      c = h + $urandom_range(0, width);
    end else begin
      c = $urandom();
      h = $urandom();
      l = $urandom();
    end
  endtask

  task automatic test_default_window();
    send_bar(32'd0, 32'd0, 32'd0, 1'b1);                   pace();
    send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, 1'b0);       pace();
    send_bar(32'd500, 32'd600, 32'd400, 1'b0);             pace();
    send_bar(32'd550, 32'd600, 32'd500, 1'b0);             pace();
    send_bar(32'd520, 32'd560, 32'd480, 1'b0);             pace();
    send_bar(32'd600, 32'd600, 32'd590, 1'b0);             pace();
    send_bar(32'd580, 32'd610, 32'd570, 1'b0);             pace();
    send_bar(32'd410, 32'd600, 32'd400, 1'b0);             pace();
  endtask

  task automatic test_edge_cases();
    wait_idle();
    write_window('0);
    send_bar(32'd50, 32'd60, 32'd40, 1'b1);                pace();
    send_bar(32'd50, 32'd60, 32'd40, 1'b0);                pace();
    send_bar(32'd50, 32'd60, 32'd40, 1'b0);                pace();
    send_bar(32'd60, 32'd60, 32'd40, 1'b0);                pace();
    send_bar(32'd40, 32'd60, 32'd40, 1'b0);                pace();
    // flat and inverted range
    send_bar(32'd70, 32'd70, 32'd70, 1'b0);                pace();
    send_bar(32'd70, 32'd60, 32'd80, 1'b0);                pace();
    // close far outside the range, then just outside
    send_bar(32'd1000, 32'd110, 32'd100, 1'b0);            pace();
    send_bar(32'd0, 32'd1010, 32'd1000, 1'b0);             pace();
    send_bar(32'd115, 32'd110, 32'd100, 1'b0);             pace();
    send_bar(32'd85, 32'd110, 32'd100, 1'b0);              pace();
    send_bar(PRICE_MAX, PRICE_MAX - 1, 32'd0, 1'b0);       pace();
    send_bar(32'd0, PRICE_MAX, 32'd1, 1'b0);               pace();
    send_bar(PRICE_MAX, PRICE_MAX, 32'd0, 1'b0);           pace();
    // restart in the middle of a series
    send_bar(32'd5, 32'd9, 32'd1, 1'b1);                   pace();
    send_bar(32'd5, 32'd9, 32'd1, 1'b0);                   pace();
    send_bar(32'd5, 32'd9, 32'd1, 1'b0);                   pace();
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0]   win_list [9];
    logic [PRICE_W-1:0] c;
    logic [PRICE_W-1:0] h;
    logic [PRICE_W-1:0] l;
    logic               start;
    win_list[0] = 7'd1;
    win_list[1] = 7'd64;
    win_list[2] = 7'd127;
    win_list[3] = 7'd2;
    win_list[4] = 7'd65;
    win_list[5] = 7'd17;
    for (int i = 6; i < 9; i++) win_list[i] = CFG_W'($urandom_range(0, 127));
    foreach (win_list[p]) begin
      wait_idle();
      // a new series after every window change keeps the walk on written entries
      write_window(win_list[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        start = (i == 0) || ($urandom_range(0, 8 * active_window() + 40) == 0);
        if (start) new_market();
        make_bar(c, h, l);
        send_bar(c, h, l, start);
        pace();
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick = stall_tick + 1;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (stall_tick % 8 == 0);
      default: out_ready <= (stall_tick % 16 >= 5);
    endcase
  end

  always @(posedge clk) begin : check_results
    smoothed_bar_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("unexpected result beat: smoothed_value %0d value_valid %0b",
               smoothed_value, value_valid);
      end else begin
        want = pending_results.pop_front();
        if (smoothed_value !== want.value) begin
          mismatch_count++;
          $error("smoothed_value: expected %0d, actual %0d", want.value, smoothed_value);
        end
        if (value_valid !== want.valid) begin
          mismatch_count++;
          $error("value_valid: expected %0b, actual %0b", want.valid, value_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    close_price  = '0;
    high_price   = '0;
    low_price    = '0;
    series_start = 1'b0;
    out_ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_window();
    test_edge_cases();
    test_random_windows();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
